[src/orbit_average_interpolator_defines.svh]
// assertion helpers shared by the rtl
`ifndef ORBIT_AVERAGE_INTERPOLATOR_DEFINES_SVH
`define ORBIT_AVERAGE_INTERPOLATOR_DEFINES_SVH

// condition in the same cycle
`define OAI_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);

// condition in the next cycle
`define OAI_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

[src/oai_pkg.sv]
package oai_pkg;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int MODE_WIDTH  = 2;
    localparam int AVAIL_WIDTH = 3;

    localparam logic [MODE_WIDTH-1:0] MODE_NONE     = 2'd0;
    localparam logic [MODE_WIDTH-1:0] MODE_LINEAR   = 2'd1;
    localparam logic [MODE_WIDTH-1:0] MODE_SPLINE   = 2'd2;
    localparam logic [MODE_WIDTH-1:0] MODE_IDENTITY = 2'd3;

    localparam logic [AVAIL_WIDTH-1:0] AVAIL_ONE  = 3'd1;
    localparam logic [AVAIL_WIDTH-1:0] AVAIL_TWO  = 3'd2;
    localparam logic [AVAIL_WIDTH-1:0] AVAIL_FOUR = 3'd4;

    typedef enum logic [1:0] {
        KIND_BYPASS,
        KIND_LINEAR,
        KIND_SPLINE
    } kind_t;

endpackage

[src/orbit_average_interpolator.sv]
// orbit_average_interpolator
// turns an escape count and up to four orbit addend averages into one smoothed
// colouring value, q-format with FRAC_BITS fraction bits, saturated
// input channel: s_valid/s_ready with the count, the addend count and addends
// result channel: m_valid/m_ready with m_color_value, one result per request
// mode register: written through cfg_wr_en/cfg_wr_data; the user must write it
// only while the block is idle, the block itself does not enforce this
// throughput: one request per cycle while m_ready holds; seven register
// stages (input decode, square, cube, weights, four multipliers, sum,
// round and saturate) each take one new request per cycle
// a stalled m_ready holds the result; stages fill their bubbles and then
// s_ready drops, nothing is lost or repeated
// reset: synchronous, active low; clears all valid bits and the mode to none
`include "orbit_average_interpolator_defines.svh"

module orbit_average_interpolator #(
    parameter int FRAC_BITS   = oai_pkg::FRAC_BITS_DEF,
    parameter int VALUE_WIDTH = oai_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [oai_pkg::MODE_WIDTH-1:0]       cfg_wr_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [VALUE_WIDTH-1:0]        s_iteration_count,
    input  logic [oai_pkg::AVAIL_WIDTH-1:0]      s_addends_available,
    input  logic signed [VALUE_WIDTH-1:0]        s_addend_0,
    input  logic signed [VALUE_WIDTH-1:0]        s_addend_1,
    input  logic signed [VALUE_WIDTH-1:0]        s_addend_2,
    input  logic signed [VALUE_WIDTH-1:0]        s_addend_3,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [VALUE_WIDTH-1:0]        m_color_value
);
    import oai_pkg::*;

    localparam int FW = FRAC_BITS;
    localparam int VW = VALUE_WIDTH;
    localparam int WW = FW + 4;
    localparam int PW = WW + VW;
    localparam int SW = PW + 3;

    localparam logic signed [WW-1:0] ONE_W = WW'(1) << FW;
    localparam logic signed [SW-1:0] RND_LIN = SW'(1) << (FW - 1);
    localparam logic signed [SW-1:0] RND_SPL = SW'(1) << FW;
    localparam logic signed [SW-1:0] VMAX_S = {{(SW-VW+1){1'b0}}, {(VW-1){1'b1}}};
    localparam logic signed [SW-1:0] VMIN_S = {{(SW-VW+1){1'b1}}, {(VW-1){1'b0}}};

    logic [MODE_WIDTH-1:0] mode_reg;

    // stage valid bits and load enables
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, m_valid_reg;
    logic ld1, ld2, ld3, ld4, ld5, ld6, ld_out;

    // stage 1: decoded request
    kind_t                 kind1_reg;
    logic signed [VW-1:0]  byp1_reg;
    logic [FW-1:0]         d1_reg;
    logic signed [VW-1:0]  a1_reg [4];
    kind_t                 kind1_next;
    logic signed [VW-1:0]  byp1_next;
    logic [AVAIL_WIDTH-1:0] avail;
    logic [MODE_WIDTH-1:0] eff_mode;

    // stage 2: square
    kind_t                 kind2_reg;
    logic signed [VW-1:0]  byp2_reg;
    logic [FW-1:0]         d2_reg, dd2_reg;
    logic signed [VW-1:0]  a2_reg [4];
    logic [2*FW-1:0]       sq_next;

    // stage 3: cube
    kind_t                 kind3_reg;
    logic signed [VW-1:0]  byp3_reg;
    logic [FW-1:0]         d3_reg, dd3_reg, ddd3_reg;
    logic signed [VW-1:0]  a3_reg [4];
    logic [2*FW-1:0]       cu_next;

    // stage 4: weights
    kind_t                 kind4_reg;
    logic signed [VW-1:0]  byp4_reg;
    logic signed [WW-1:0]  w4_reg [4];
    logic signed [VW-1:0]  a4_reg [4];
    logic signed [WW-1:0]  w_next [4];
    logic signed [WW-1:0]  ed, e2, e3;

    // stage 5: products
    kind_t                 kind5_reg;
    logic signed [VW-1:0]  byp5_reg;
    logic signed [PW-1:0]  p5_reg [4];

    // stage 6: sum
    kind_t                 kind6_reg;
    logic signed [VW-1:0]  byp6_reg;
    logic signed [SW-1:0]  sum6_reg;

    // output
    logic signed [VW-1:0]  m_color_value_reg;
    logic signed [SW-1:0]  rnd_next, shr_next;
    logic signed [VW-1:0]  color_next;

    assign ld_out = !m_valid_reg || m_ready;
    assign ld6    = !v6_reg || ld_out;
    assign ld5    = !v5_reg || ld6;
    assign ld4    = !v4_reg || ld5;
    assign ld3    = !v3_reg || ld4;
    assign ld2    = !v2_reg || ld3;
    assign ld1    = !v1_reg || ld2;

    assign s_ready       = ld1;
    assign m_valid       = m_valid_reg;
    assign m_color_value = m_color_value_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_NONE;
        end else if (cfg_wr_en) begin
            mode_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            v6_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (ld1)    v1_reg      <= s_valid;
            if (ld2)    v2_reg      <= v1_reg;
            if (ld3)    v3_reg      <= v2_reg;
            if (ld4)    v4_reg      <= v3_reg;
            if (ld5)    v5_reg      <= v4_reg;
            if (ld6)    v6_reg      <= v5_reg;
            if (ld_out) m_valid_reg <= v6_reg;
        end
    end

    // decode with the fallback chain
    always_comb begin
        avail      = (s_addends_available > AVAIL_FOUR) ? AVAIL_FOUR : s_addends_available;
        eff_mode   = mode_reg;
        kind1_next = KIND_BYPASS;
        byp1_next  = s_iteration_count;
        if (eff_mode == MODE_SPLINE && avail < AVAIL_FOUR) begin
            eff_mode = MODE_LINEAR;
        end
        if (eff_mode == MODE_LINEAR && avail < AVAIL_TWO) begin
            eff_mode = MODE_NONE;
        end
        if (mode_reg != MODE_IDENTITY && !s_iteration_count[VW-1]) begin
            case (eff_mode)
                MODE_NONE: begin
                    if (avail >= AVAIL_ONE) begin
                        byp1_next = s_addend_0;
                    end
                end
                MODE_LINEAR: kind1_next = KIND_LINEAR;
                MODE_SPLINE: kind1_next = KIND_SPLINE;
                default:     kind1_next = KIND_BYPASS;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (ld1) begin
            kind1_reg <= kind1_next;
            byp1_reg  <= byp1_next;
            d1_reg    <= s_iteration_count[FW-1:0];
            a1_reg[0] <= s_addend_0;
            a1_reg[1] <= s_addend_1;
            a1_reg[2] <= s_addend_2;
            a1_reg[3] <= s_addend_3;
        end
    end

    assign sq_next = d1_reg * d1_reg;

    always_ff @(posedge aclk) begin
        if (ld2) begin
            kind2_reg <= kind1_reg;
            byp2_reg  <= byp1_reg;
            d2_reg    <= d1_reg;
            dd2_reg   <= sq_next[2*FW-1:FW];
            a2_reg    <= a1_reg;
        end
    end

    assign cu_next = dd2_reg * d2_reg;

    always_ff @(posedge aclk) begin
        if (ld3) begin
            kind3_reg <= kind2_reg;
            byp3_reg  <= byp2_reg;
            d3_reg    <= d2_reg;
            dd3_reg   <= dd2_reg;
            ddd3_reg  <= cu_next[2*FW-1:FW];
            a3_reg    <= a2_reg;
        end
    end

    // catmull-rom weights, or the two linear blend weights
    always_comb begin
        ed = {4'b0000, d3_reg};
        e2 = {4'b0000, dd3_reg};
        e3 = {4'b0000, ddd3_reg};
        if (kind3_reg == KIND_SPLINE) begin
            w_next[0] = e3 - e2;
            w_next[1] = ed + (e2 <<< 2) - ((e3 <<< 1) + e3);
            w_next[2] = (ONE_W <<< 1) - ((e2 <<< 2) + e2) + ((e3 <<< 1) + e3);
            w_next[3] = (e2 <<< 1) - ed - e3;
        end else begin
            w_next[0] = ed;
            w_next[1] = ONE_W - ed;
            w_next[2] = '0;
            w_next[3] = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld4) begin
            kind4_reg <= kind3_reg;
            byp4_reg  <= byp3_reg;
            w4_reg    <= w_next;
            a4_reg    <= a3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld5) begin
            kind5_reg <= kind4_reg;
            byp5_reg  <= byp4_reg;
            for (int i = 0; i < 4; i++) begin
                p5_reg[i] <= PW'(w4_reg[i]) * PW'(a4_reg[i]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ld6) begin
            kind6_reg <= kind5_reg;
            byp6_reg  <= byp5_reg;
            sum6_reg  <= SW'(p5_reg[0]) + SW'(p5_reg[1]) + SW'(p5_reg[2]) + SW'(p5_reg[3]);
        end
    end

    // round half up, then saturate
    always_comb begin
        rnd_next = sum6_reg + ((kind6_reg == KIND_SPLINE) ? RND_SPL : RND_LIN);
        shr_next = (kind6_reg == KIND_SPLINE) ? (rnd_next >>> (FW + 1)) : (rnd_next >>> FW);
        if (kind6_reg == KIND_BYPASS) begin
            color_next = byp6_reg;
        end else if (shr_next > VMAX_S) begin
            color_next = VMAX_S[VW-1:0];
        end else if (shr_next < VMIN_S) begin
            color_next = VMIN_S[VW-1:0];
        end else begin
            color_next = shr_next[VW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ld_out) begin
            m_color_value_reg <= color_next;
        end
    end

    `OAI_ASSERT_NEXT(a_accept_fills, s_valid && s_ready, v1_reg, "accepted request not in stage one")
    `OAI_ASSERT_NOW(a_out_from_pipe, $rose(m_valid_reg), $past(v6_reg), "result without a source")
    `OAI_ASSERT_NEXT(a_identity_bypass, s_valid && s_ready && mode_reg == MODE_IDENTITY, kind1_reg == KIND_BYPASS && byp1_reg == $past(s_iteration_count), "identity mode not passed through")

endmodule

[tb/orbit_average_interpolator_tb.sv]
`timescale 1ns / 1ps

module orbit_average_interpolator_tb;
    import oai_pkg::*;

    localparam int VW = VALUE_WIDTH_DEF;
    localparam int FB = FRAC_BITS_DEF;
    localparam int CLK_PERIOD = 10;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 20;

    localparam logic [VW-1:0] VMAX_V = {1'b0, {(VW-1){1'b1}}};
    localparam logic [VW-1:0] VMIN_V = {1'b1, {(VW-1){1'b0}}};
    localparam longint ONE_Q = longint'(1) << FB;
    localparam longint VMAX_L = (longint'(1) << (VW-1)) - 1;
    localparam longint VMIN_L = -(longint'(1) << (VW-1));

    typedef struct packed {
        logic [VW-1:0]          count;
        logic [AVAIL_WIDTH-1:0] avail;
        logic [VW-1:0]          a0;
        logic [VW-1:0]          a1;
        logic [VW-1:0]          a2;
        logic [VW-1:0]          a3;
    } pixel_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [MODE_WIDTH-1:0]  cfg_wr_data = MODE_NONE;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [VW-1:0]          s_iteration_count = '0;
    logic [AVAIL_WIDTH-1:0] s_addends_available = '0;
    logic [VW-1:0]          s_addend_0 = '0;
    logic [VW-1:0]          s_addend_1 = '0;
    logic [VW-1:0]          s_addend_2 = '0;
    logic [VW-1:0]          s_addend_3 = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [VW-1:0]          m_color_value;

    logic [MODE_WIDTH-1:0]  mode_shadow = MODE_NONE;
    logic [VW-1:0]          color_expected [$];
    int                     mismatches = 0;
    int                     requests_sent = 0;
    int                     results_checked = 0;
    int                     mode_requests [4] = '{0, 0, 0, 0};
    int                     quiet_cycles = 0;
    int unsigned            stall_left = 0;
    bit                     steady = 1'b0;

    orbit_average_interpolator dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_wr_data         (cfg_wr_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_iteration_count   (s_iteration_count),
        .s_addends_available (s_addends_available),
        .s_addend_0          (s_addend_0),
        .s_addend_1          (s_addend_1),
        .s_addend_2          (s_addend_2),
        .s_addend_3          (s_addend_3),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_color_value       (m_color_value)
    );

    always #(CLK_PERIOD/2) aclk = ~aclk;

    function automatic logic [VW-1:0] predict_color(input logic [MODE_WIDTH-1:0] sel,
                                                    input pixel_t px);
        longint a0, a1, a2, a3, d, d2, d3, w0, w1, w2, w3, acc, res;
        logic [AVAIL_WIDTH-1:0] avail;
        logic [MODE_WIDTH-1:0] path;
        a0 = $signed(px.a0);
        a1 = $signed(px.a1);
        a2 = $signed(px.a2);
        a3 = $signed(px.a3);
        res = $signed(px.count);
        avail = (px.avail > AVAIL_FOUR) ? AVAIL_FOUR : px.avail;
        path = sel;
        if (path != MODE_IDENTITY && res >= 0) begin
            d = px.count[FB-1:0];
            // fall back to a simpler blend when addends are missing
            if (path == MODE_SPLINE && avail < AVAIL_FOUR) path = MODE_LINEAR;
            if (path == MODE_LINEAR && avail < AVAIL_TWO) path = MODE_NONE;
            if (path == MODE_NONE) begin
                if (avail >= AVAIL_ONE) res = a0;
            end else if (path == MODE_LINEAR) begin
                acc = d * a0 + (ONE_Q - d) * a1;
                res = (acc + (longint'(1) << (FB-1))) >>> FB;
            end else begin
                d2 = (d * d) >>> FB;
                d3 = (d2 * d) >>> FB;
                w0 = d3 - d2;
                w1 = d + 4 * d2 - 3 * d3;
                w2 = 2 * ONE_Q - 5 * d2 + 3 * d3;
                w3 = -d + 2 * d2 - d3;
                acc = w0 * a0 + w1 * a1 + w2 * a2 + w3 * a3;
                res = (acc + (longint'(1) << FB)) >>> (FB + 1);
            end
        end
        if (res > VMAX_L) res = VMAX_L;
        else if (res < VMIN_L) res = VMIN_L;
        return res[VW-1:0];
    endfunction

    function automatic pixel_t make_pixel(input logic [VW-1:0] count,
                                          input logic [AVAIL_WIDTH-1:0] avail,
                                          input logic [VW-1:0] a0, a1, a2, a3);
        pixel_t px;
        px.count = count;
        px.avail = avail;
        px.a0 = a0;
        px.a1 = a1;
        px.a2 = a2;
        px.a3 = a3;
        return px;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [VW-1:0] pick_value();
        logic [VW-1:0] v;
        v = $urandom();
        case ($urandom_range(0, 9))
            0: v = VMAX_V;
            1: v = VMIN_V;
            2: v = '0;
            3: v = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
            default: ;
        endcase
        return v;
    endfunction

    function automatic pixel_t pick_pixel();
        pixel_t px;
        px.count = $urandom();
        case ($urandom_range(0, 9))
            0: px.count[VW-1] = 1'b1;
            1: px.count = VMIN_V;
            2: begin
                px.count[VW-1] = 1'b0;
                px.count[FB-1:0] = '0;
            end
            3: begin
                px.count[VW-1] = 1'b0;
                px.count[FB-1:0] = '1;
            end
            4: px.count = VMAX_V;
            default: px.count[VW-1] = 1'b0;
        endcase
        if ($urandom_range(0, 9) < 6) px.avail = AVAIL_WIDTH'($urandom_range(4, 7));
        else px.avail = AVAIL_WIDTH'($urandom_range(0, 3));
        px.a0 = pick_value();
        px.a1 = pick_value();
        px.a2 = pick_value();
        px.a3 = pick_value();
        return px;
    endfunction

    // receiver side back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (steady) begin
            m_ready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else begin
            stall_left <= pick_gap();
            m_ready <= 1'b1;
        end
    end

    // outputs only change at the rising edge, so the falling edge sees settled values
    always @(negedge aclk) begin : check_result
        logic [VW-1:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (color_expected.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %0d",
                         $time, $signed(m_color_value));
                mismatches++;
            end else begin
                want = color_expected.pop_front();
                if (m_color_value !== want) begin
                    $display("%0t: color_value mismatch, expected %0d actual %0d",
                             $time, $signed(want), $signed(m_color_value));
                    mismatches++;
                end
                results_checked++;
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: nothing moved for %0d cycles", $time, quiet_cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_pixel(input pixel_t px);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_iteration_count <= px.count;
        s_addends_available <= px.avail;
        s_addend_0 <= px.a0;
        s_addend_1 <= px.a1;
        s_addend_2 <= px.a2;
        s_addend_3 <= px.a3;
        @(negedge aclk);
        while (!s_ready) @(negedge aclk);
        color_expected.push_back(predict_color(mode_shadow, px));
        mode_requests[mode_shadow]++;
        requests_sent++;
        @(posedge aclk);
    endtask

    task automatic write_mode(input logic [MODE_WIDTH-1:0] sel);
        s_valid <= 1'b0;
        do @(posedge aclk); while (color_expected.size() != 0);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= sel;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        mode_shadow = sel;
    endtask

    // mode must come out of reset as none
    task automatic test_reset_mode();
        send_pixel(make_pixel(32'h0004_2000, AVAIL_ONE, 32'h0123_4567, VMAX_V, VMIN_V, '0));
        send_pixel(make_pixel(32'h0007_0001, '0, VMAX_V, VMAX_V, VMAX_V, VMAX_V));
    endtask

    task automatic test_edge_cases();
        for (int m = MODE_NONE; m <= MODE_IDENTITY; m++) begin
            write_mode(MODE_WIDTH'(m));
            // inside the set
            send_pixel(make_pixel(32'hFFFF_FFFF, AVAIL_FOUR,
                                  32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000));
            send_pixel(make_pixel('0, AVAIL_FOUR, VMAX_V, VMIN_V, VMAX_V, VMIN_V));
            // largest count, addend count above four, low saturation in spline
            send_pixel(make_pixel(VMAX_V, 3'd7, VMAX_V, VMIN_V, VMIN_V, VMAX_V));
            // half fraction: rounding tie in linear, high saturation in spline
            send_pixel(make_pixel(32'h0003_8000, AVAIL_FOUR, VMIN_V, VMAX_V, VMAX_V, VMIN_V));
            // three addends: spline drops to linear
            send_pixel(make_pixel(32'h0002_4000, 3'd3,
                                  32'hFFFE_0000, 32'h0002_0000, 32'h0005_0000, 32'h7000_0000));
            // one addend: linear drops to none
            send_pixel(make_pixel(32'h0005_C000, AVAIL_ONE,
                                  32'h1234_5678, VMIN_V, VMAX_V, 32'h8765_4321));
        end
    endtask

    task automatic test_full_rate();
        steady = 1'b1;
        write_mode(MODE_SPLINE);
        repeat (40) send_pixel(pick_pixel());
        steady = 1'b0;
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 8; phase++) begin
            if (phase == 0) write_mode(MODE_NONE);
            else if (phase == 1) write_mode(MODE_IDENTITY);
            else write_mode(MODE_WIDTH'($urandom_range(MODE_NONE, MODE_IDENTITY)));
            steady = ($urandom_range(0, 3) == 0);
            repeat (85) send_pixel(pick_pixel());
        end
        steady = 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_mode();
        test_edge_cases();
        test_full_rate();
        test_random_traffic();
        s_valid <= 1'b0;
        while (color_expected.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("%0d requests sent and %0d results checked, fallbacks and saturation included",
                 requests_sent, results_checked);
        $display("requests per mode: none %0d, linear %0d, spline %0d, identity %0d",
                 mode_requests[MODE_NONE], mode_requests[MODE_LINEAR],
                 mode_requests[MODE_SPLINE], mode_requests[MODE_IDENTITY]);
        if (mismatches == 0 && color_expected.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
